// ----- design/rvd_pkg.sv -----
// Package for the RV32I instruction decoder: opcode and funct codes,
// mnemonic codes and the decoded result type.
// No dependencies.
package rvd_pkg;

    // Major opcodes, bits 6..0
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // Branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // Load / store width funct3
    localparam logic [2:0] F3_BYTE  = 3'd0;
    localparam logic [2:0] F3_HALF  = 3'd1;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_BYTEU = 3'd4;
    localparam logic [2:0] F3_HALFU = 3'd5;

    // ALU funct3, shared by OP and OP-IMM
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // System funct3
    localparam logic [2:0] F3_PRIV   = 3'd0;
    localparam logic [2:0] F3_CSRRW  = 3'd1;
    localparam logic [2:0] F3_CSRRS  = 3'd2;
    localparam logic [2:0] F3_CSRRC  = 3'd3;
    localparam logic [2:0] F3_CSRRWI = 3'd5;
    localparam logic [2:0] F3_CSRRSI = 3'd6;
    localparam logic [2:0] F3_CSRRCI = 3'd7;

    // funct7 variants
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Whole-word encodings
    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    // Mnemonic codes
    localparam logic [5:0] MN_LUI    = 6'd0;
    localparam logic [5:0] MN_AUIPC  = 6'd1;
    localparam logic [5:0] MN_JAL    = 6'd2;
    localparam logic [5:0] MN_JALR   = 6'd3;
    localparam logic [5:0] MN_BEQ    = 6'd4;
    localparam logic [5:0] MN_BNE    = 6'd5;
    localparam logic [5:0] MN_BLT    = 6'd6;
    localparam logic [5:0] MN_BGE    = 6'd7;
    localparam logic [5:0] MN_BLTU   = 6'd8;
    localparam logic [5:0] MN_BGEU   = 6'd9;
    localparam logic [5:0] MN_LB     = 6'd10;
    localparam logic [5:0] MN_LH     = 6'd11;
    localparam logic [5:0] MN_LW     = 6'd12;
    localparam logic [5:0] MN_LBU    = 6'd13;
    localparam logic [5:0] MN_LHU    = 6'd14;
    localparam logic [5:0] MN_SB     = 6'd15;
    localparam logic [5:0] MN_SH     = 6'd16;
    localparam logic [5:0] MN_SW     = 6'd17;
    localparam logic [5:0] MN_ADDI   = 6'd18;
    localparam logic [5:0] MN_SLTI   = 6'd19;
    localparam logic [5:0] MN_SLTIU  = 6'd20;
    localparam logic [5:0] MN_XORI   = 6'd21;
    localparam logic [5:0] MN_ORI    = 6'd22;
    localparam logic [5:0] MN_ANDI   = 6'd23;
    localparam logic [5:0] MN_SLLI   = 6'd24;
    localparam logic [5:0] MN_SRLI   = 6'd25;
    localparam logic [5:0] MN_SRAI   = 6'd26;
    localparam logic [5:0] MN_ADD    = 6'd27;
    localparam logic [5:0] MN_SUB    = 6'd28;
    localparam logic [5:0] MN_SLL    = 6'd29;
    localparam logic [5:0] MN_SLT    = 6'd30;
    localparam logic [5:0] MN_SLTU   = 6'd31;
    localparam logic [5:0] MN_XOR    = 6'd32;
    localparam logic [5:0] MN_SRL    = 6'd33;
    localparam logic [5:0] MN_SRA    = 6'd34;
    localparam logic [5:0] MN_OR     = 6'd35;
    localparam logic [5:0] MN_AND    = 6'd36;
    localparam logic [5:0] MN_ECALL  = 6'd37;
    localparam logic [5:0] MN_EBREAK = 6'd38;
    localparam logic [5:0] MN_CSRRW  = 6'd39;
    localparam logic [5:0] MN_CSRRS  = 6'd40;
    localparam logic [5:0] MN_CSRRC  = 6'd41;
    localparam logic [5:0] MN_CSRRWI = 6'd42;
    localparam logic [5:0] MN_CSRRSI = 6'd43;
    localparam logic [5:0] MN_CSRRCI = 6'd44;

    // Decoded result of one item
    typedef struct packed {
        logic [5:0]         mnemonic_code;
        logic               illegal;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [31:0]        target_addr;
        logic [11:0]        csr_number;
    } result_t;

endpackage

// ----- design/rvd_if.sv -----
// Channel interfaces of the RV32I instruction decoder: instruction items in,
// decoded result items out. Valid/ready handshake. No dependencies.
interface rvd_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_addr;
    logic [31:0] instr_word;

    modport source (output valid, output instr_addr, output instr_word, input ready);
    modport sink   (input valid, input instr_addr, input instr_word, output ready);
endinterface

interface rvd_result_if;
    logic               valid;
    logic               ready;
    logic [5:0]         mnemonic_code;
    logic               illegal;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        target_addr;
    logic [11:0]        csr_number;

    modport source (
        output valid, output mnemonic_code, output illegal, output dest_reg,
        output src1_reg, output src2_reg, output immediate, output target_addr,
        output csr_number, input ready
    );
    modport sink (
        input valid, input mnemonic_code, input illegal, input dest_reg,
        input src1_reg, input src2_reg, input immediate, input target_addr,
        input csr_number, output ready
    );
endinterface

// ----- design/rvd_decode.sv -----
// Combinational RV32I decode: mnemonic, register fields, immediate, csr number
// and branch/jal target for one instruction word. Depends on rvd_pkg.
module rvd_decode (
    input  logic [31:0]     instr_addr,
    input  logic [31:0]     instr_word,
    output rvd_pkg::result_t res
);
    import rvd_pkg::*;

    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] imm_sh;
    logic [5:0]  kind;
    logic        known;
    logic        has_target;
    logic [31:0] imm;
    logic [11:0] csr;

    assign opcode = instr_word[6:0];
    assign funct3 = instr_word[14:12];
    assign funct7 = instr_word[31:25];

    // Format immediates
    assign imm_i  = {{20{instr_word[31]}}, instr_word[31:20]};
    assign imm_s  = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b  = {{20{instr_word[31]}}, instr_word[7], instr_word[30:25],
                     instr_word[11:8], 1'b0};
    assign imm_j  = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
                     instr_word[30:21], 1'b0};
    assign imm_u  = {12'd0, instr_word[31:12]};
    assign imm_sh = {27'd0, instr_word[24:20]};

    // Classify the word and pick its immediate
    always_comb
    begin
        kind       = MN_LUI;
        known      = 1'b1;
        has_target = 1'b0;
        imm        = '0;
        csr        = '0;
        unique case (opcode)
            OPC_LUI:
            begin
                kind = MN_LUI;
                imm  = imm_u;
            end
            OPC_AUIPC:
            begin
                kind = MN_AUIPC;
                imm  = imm_u;
            end
            OPC_JAL:
            begin
                kind       = MN_JAL;
                imm        = imm_j;
                has_target = 1'b1;
            end
            OPC_JALR:
            begin
                kind = MN_JALR;
                imm  = imm_i;
            end
            OPC_BRANCH:
            begin
                imm        = imm_b;
                has_target = 1'b1;
                unique case (funct3)
                    F3_BEQ:  kind = MN_BEQ;
                    F3_BNE:  kind = MN_BNE;
                    F3_BLT:  kind = MN_BLT;
                    F3_BGE:  kind = MN_BGE;
                    F3_BLTU: kind = MN_BLTU;
                    F3_BGEU: kind = MN_BGEU;
                    default: known = 1'b0;
                endcase
            end
            OPC_LOAD:
            begin
                imm = imm_i;
                unique case (funct3)
                    F3_BYTE:  kind = MN_LB;
                    F3_HALF:  kind = MN_LH;
                    F3_WORD:  kind = MN_LW;
                    F3_BYTEU: kind = MN_LBU;
                    F3_HALFU: kind = MN_LHU;
                    default:  known = 1'b0;
                endcase
            end
            OPC_STORE:
            begin
                imm = imm_s;
                unique case (funct3)
                    F3_BYTE: kind = MN_SB;
                    F3_HALF: kind = MN_SH;
                    F3_WORD: kind = MN_SW;
                    default: known = 1'b0;
                endcase
            end
            OPC_OP_IMM:
            begin
                imm = imm_i;
                unique case (funct3)
                    F3_ADD:  kind = MN_ADDI;
                    F3_SLT:  kind = MN_SLTI;
                    F3_SLTU: kind = MN_SLTIU;
                    F3_XOR:  kind = MN_XORI;
                    F3_OR:   kind = MN_ORI;
                    F3_AND:  kind = MN_ANDI;
                    F3_SLL:
                    begin
                        // funct7 left unchecked for slli
                        kind = MN_SLLI;
                        imm  = imm_sh;
                    end
                    default:
                    begin
                        imm = imm_sh;
                        if (funct7 == F7_BASE)
                            kind = MN_SRLI;
                        else if (funct7 == F7_ALT)
                            kind = MN_SRAI;
                        else
                            known = 1'b0;
                    end
                endcase
            end
            OPC_OP:
            begin
                unique case (funct3)
                    F3_ADD:
                    begin
                        if (funct7 == F7_BASE)
                            kind = MN_ADD;
                        else if (funct7 == F7_ALT)
                            kind = MN_SUB;
                        else
                            known = 1'b0;
                    end
                    F3_SLL:  kind = MN_SLL;
                    F3_SLT:  kind = MN_SLT;
                    F3_SLTU: kind = MN_SLTU;
                    F3_XOR:  kind = MN_XOR;
                    F3_OR:   kind = MN_OR;
                    F3_AND:  kind = MN_AND;
                    default:
                    begin
                        if (funct7 == F7_BASE)
                            kind = MN_SRL;
                        else if (funct7 == F7_ALT)
                            kind = MN_SRA;
                        else
                            known = 1'b0;
                    end
                endcase
            end
            OPC_SYSTEM:
            begin
                csr = instr_word[31:20];
                unique case (funct3)
                    F3_PRIV:
                    begin
                        csr = '0;
                        if (instr_word == WORD_ECALL)
                            kind = MN_ECALL;
                        else if (instr_word == WORD_EBREAK)
                            kind = MN_EBREAK;
                        else
                            known = 1'b0;
                    end
                    F3_CSRRW:  kind = MN_CSRRW;
                    F3_CSRRS:  kind = MN_CSRRS;
                    F3_CSRRC:  kind = MN_CSRRC;
                    F3_CSRRWI: kind = MN_CSRRWI;
                    F3_CSRRSI: kind = MN_CSRRSI;
                    F3_CSRRCI: kind = MN_CSRRCI;
                    default:   known = 1'b0;
                endcase
            end
            default: known = 1'b0;
        endcase
    end

    // Force the kind to LUI and drop immediate, target and csr for unrecognized words
    always_comb
    begin
        res.mnemonic_code = known ? kind : MN_LUI;
        res.illegal       = ~known;
        res.dest_reg      = instr_word[11:7];
        res.src1_reg      = instr_word[19:15];
        res.src2_reg      = instr_word[24:20];
        res.immediate     = known ? imm : '0;
        res.target_addr   = (known && has_target) ? (instr_addr + imm) : '0;
        res.csr_number    = known ? csr : '0;
    end

endmodule

// ----- design/rv32i_instruction_decoder.sv -----
// Top level of the RV32I instruction decoder: input register, decode logic,
// result register. Depends on rvd_pkg, rvd_if and rvd_decode.
//
// Takes one instruction item (address and word) per clock and returns one
// decoded result item per instruction, in order: mnemonic code (or the illegal
// flag), rd/rs1/rs2 fields, the format immediate, the csr number and, for
// branches and jal, the target address. Throughput is one item per cycle
// while the result side is not stalled. The accepting edge loads the input
// register, and the decode pass is then registered into the result register,
// which shows the result until it leaves.
// A held result does not stop the next item from being accepted while the
// input register is free; back-pressure reaches the input only when both
// registers are full.
module rv32i_instruction_decoder (
    input  logic           clk,
    input  logic           rst_n,
    rvd_instr_if.sink      instr,
    rvd_result_if.source   result
);
    import rvd_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_addr_reg;
    logic [31:0] s1_word_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    result_t     res_reg;
    result_t     dec_res;
    logic        res_ready;
    logic        s1_ready;

    // Stage enables
    assign res_ready   = ~res_valid_reg | result.ready;
    assign s1_ready    = ~s1_valid_reg | res_ready;
    assign instr.ready = s1_ready;

    assign s1_valid_next  = s1_ready ? instr.valid : s1_valid_reg;
    assign res_valid_next = res_ready ? s1_valid_reg : res_valid_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (s1_ready && instr.valid)
        begin
            s1_addr_reg <= instr.instr_addr;
            s1_word_reg <= instr.instr_word;
        end
    end

    rvd_decode u_decode (
        .instr_addr (s1_addr_reg),
        .instr_word (s1_word_reg),
        .res        (dec_res)
    );

    // Advance the decoded item into the result register
    always_ff @(posedge clk)
    begin
        if (res_ready && s1_valid_reg)
            res_reg <= dec_res;
    end

    assign result.valid         = res_valid_reg;
    assign result.mnemonic_code = res_reg.mnemonic_code;
    assign result.illegal       = res_reg.illegal;
    assign result.dest_reg      = res_reg.dest_reg;
    assign result.src1_reg      = res_reg.src1_reg;
    assign result.src2_reg      = res_reg.src2_reg;
    assign result.immediate     = res_reg.immediate;
    assign result.target_addr   = res_reg.target_addr;
    assign result.csr_number    = res_reg.csr_number;

`ifndef NO_ASSERTIONS
    // An accepted item always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (instr.valid && instr.ready) |=> s1_valid_reg)
        else $error("accepted item not held in input register");

    // A result only appears when an item was waiting in the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(s1_valid_reg))
        else $error("result shown without a decoded item");

    // Illegal words carry no kind, immediate, target or csr
    a_illegal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.illegal) |->
            (result.mnemonic_code == MN_LUI && result.immediate == 0 &&
             result.target_addr == 0 && result.csr_number == 0))
        else $error("illegal result carries decoded fields");

    // A nonzero csr number only comes with a csr kind
    a_csr_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.csr_number != 0) |->
            (result.mnemonic_code >= MN_CSRRW && result.mnemonic_code <= MN_CSRRCI))
        else $error("csr number on a non-csr kind");

    // A nonzero target only comes with jal or a branch
    a_target_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.target_addr != 0) |->
            (result.mnemonic_code == MN_JAL ||
             (result.mnemonic_code >= MN_BEQ && result.mnemonic_code <= MN_BGEU)))
        else $error("target on a kind without one");
`endif

endmodule

// ----- test/rv32i_instruction_decoder_test.sv -----
`timescale 1ns / 100ps
// Testbench for rv32i_instruction_decoder: directed table plus random
// instruction stream, checked against typed rows or a local decode predictor.
// Depends on rvd_pkg, rvd_if and the decoder RTL.
module rv32i_instruction_decoder_test;
    import rvd_pkg::*;

    localparam int          RANDOM_ITEMS   = 500;
    localparam int          NUM_KINDS      = MN_CSRRCI + 1;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          HOLDOFF_AT     = 100;
    localparam int          HOLDOFF_CYCLES = 250;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int unsigned TIMEOUT_NS     = 2_000_000;

    typedef struct {
        logic [31:0] addr;
        logic [31:0] word;
        bit          typed;
        result_t     decoded;
    } stim_row_t;

    typedef struct {
        logic [31:0] word;
        result_t     decoded;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n;

    rvd_instr_if  instr_ch ();
    rvd_result_if result_ch ();

    stim_row_t directed_rows [$];
    pending_t  pending_decodes [$];

    int               results_seen  = 0;
    int               illegal_seen  = 0;
    int               failures      = 0;
    bit               holdoff_done  = 1'b0;
    bit               no_gaps       = 1'b0;
    bit [NUM_KINDS-1:0] kinds_seen  = '0;

    rv32i_instruction_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predict the decoded result of one instruction word at an address
    function automatic result_t decode_instr(input logic [31:0] addr, input logic [31:0] word);
        result_t     res;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [31:0] shamt;
        logic        legal;
        opc   = word[6:0];
        f3    = word[14:12];
        f7    = word[31:25];
        imm_i = {{20{word[31]}}, word[31:20]};
        imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
        imm_b = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
        imm_j = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
        shamt = {27'd0, word[24:20]};
        legal = 1'b1;
        res = '0;
        res.dest_reg = word[11:7];
        res.src1_reg = word[19:15];
        res.src2_reg = word[24:20];
        case (opc)
            OPC_LUI:
            begin
                res.mnemonic_code = MN_LUI;
                res.immediate = {12'd0, word[31:12]};
            end
            OPC_AUIPC:
            begin
                res.mnemonic_code = MN_AUIPC;
                res.immediate = {12'd0, word[31:12]};
            end
            OPC_JAL:
            begin
                res.mnemonic_code = MN_JAL;
                res.immediate = imm_j;
                res.target_addr = addr + imm_j;
            end
            OPC_JALR:
            begin
                // funct3 is not checked
                res.mnemonic_code = MN_JALR;
                res.immediate = imm_i;
            end
            OPC_BRANCH:
            begin
                res.immediate = imm_b;
                res.target_addr = addr + imm_b;
                case (f3)
                    F3_BEQ:  res.mnemonic_code = MN_BEQ;
                    F3_BNE:  res.mnemonic_code = MN_BNE;
                    F3_BLT:  res.mnemonic_code = MN_BLT;
                    F3_BGE:  res.mnemonic_code = MN_BGE;
                    F3_BLTU: res.mnemonic_code = MN_BLTU;
                    F3_BGEU: res.mnemonic_code = MN_BGEU;
                    default: legal = 1'b0;
                endcase
            end
            OPC_LOAD:
            begin
                res.immediate = imm_i;
                case (f3)
                    F3_BYTE:  res.mnemonic_code = MN_LB;
                    F3_HALF:  res.mnemonic_code = MN_LH;
                    F3_WORD:  res.mnemonic_code = MN_LW;
                    F3_BYTEU: res.mnemonic_code = MN_LBU;
                    F3_HALFU: res.mnemonic_code = MN_LHU;
                    default:  legal = 1'b0;
                endcase
            end
            OPC_STORE:
            begin
                res.immediate = imm_s;
                case (f3)
                    F3_BYTE: res.mnemonic_code = MN_SB;
                    F3_HALF: res.mnemonic_code = MN_SH;
                    F3_WORD: res.mnemonic_code = MN_SW;
                    default: legal = 1'b0;
                endcase
            end
            OPC_OP_IMM:
            begin
                res.immediate = imm_i;
                case (f3)
                    F3_ADD:  res.mnemonic_code = MN_ADDI;
                    F3_SLT:  res.mnemonic_code = MN_SLTI;
                    F3_SLTU: res.mnemonic_code = MN_SLTIU;
                    F3_XOR:  res.mnemonic_code = MN_XORI;
                    F3_OR:   res.mnemonic_code = MN_ORI;
                    F3_AND:  res.mnemonic_code = MN_ANDI;
                    F3_SLL:
                    begin
                        // funct7 is not checked for slli
                        res.mnemonic_code = MN_SLLI;
                        res.immediate = shamt;
                    end
                    default:
                    begin
                        res.immediate = shamt;
                        if (f7 == F7_BASE)
                            res.mnemonic_code = MN_SRLI;
                        else if (f7 == F7_ALT)
                            res.mnemonic_code = MN_SRAI;
                        else
                            legal = 1'b0;
                    end
                endcase
            end
            OPC_OP:
            begin
                case (f3)
                    F3_ADD:
                    begin
                        if (f7 == F7_BASE)
                            res.mnemonic_code = MN_ADD;
                        else if (f7 == F7_ALT)
                            res.mnemonic_code = MN_SUB;
                        else
                            legal = 1'b0;
                    end
                    F3_SLL:  res.mnemonic_code = MN_SLL;
                    F3_SLT:  res.mnemonic_code = MN_SLT;
                    F3_SLTU: res.mnemonic_code = MN_SLTU;
                    F3_XOR:  res.mnemonic_code = MN_XOR;
                    F3_SR:
                    begin
                        if (f7 == F7_BASE)
                            res.mnemonic_code = MN_SRL;
                        else if (f7 == F7_ALT)
                            res.mnemonic_code = MN_SRA;
                        else
                            legal = 1'b0;
                    end
                    F3_OR:   res.mnemonic_code = MN_OR;
                    default: res.mnemonic_code = MN_AND;
                endcase
            end
            OPC_SYSTEM:
            begin
                res.csr_number = word[31:20];
                case (f3)
                    F3_PRIV:
                    begin
                        res.csr_number = '0;
                        if (word == WORD_ECALL)
                            res.mnemonic_code = MN_ECALL;
                        else if (word == WORD_EBREAK)
                            res.mnemonic_code = MN_EBREAK;
                        else
                            legal = 1'b0;
                    end
                    F3_CSRRW:  res.mnemonic_code = MN_CSRRW;
                    F3_CSRRS:  res.mnemonic_code = MN_CSRRS;
                    F3_CSRRC:  res.mnemonic_code = MN_CSRRC;
                    F3_CSRRWI: res.mnemonic_code = MN_CSRRWI;
                    F3_CSRRSI: res.mnemonic_code = MN_CSRRSI;
                    F3_CSRRCI: res.mnemonic_code = MN_CSRRCI;
                    default:   legal = 1'b0;
                endcase
            end
            default: legal = 1'b0;
        endcase
        // Unrecognized words keep only their register slices
        if (!legal)
        begin
            res.mnemonic_code = MN_LUI;
            res.illegal       = 1'b1;
            res.immediate     = '0;
            res.target_addr   = '0;
            res.csr_number    = '0;
        end
        return res;
    endfunction

    // Build a well-formed word of the given kind over random filler bits
    function automatic logic [31:0] encode_kind(input logic [5:0] kind, input logic [31:0] fill);
        logic [31:0] w;
        w = fill;
        case (kind)
            MN_LUI:    w[6:0] = OPC_LUI;
            MN_AUIPC:  w[6:0] = OPC_AUIPC;
            MN_JAL:    w[6:0] = OPC_JAL;
            MN_JALR:   w[6:0] = OPC_JALR;
            MN_BEQ:    {w[14:12], w[6:0]} = {F3_BEQ, OPC_BRANCH};
            MN_BNE:    {w[14:12], w[6:0]} = {F3_BNE, OPC_BRANCH};
            MN_BLT:    {w[14:12], w[6:0]} = {F3_BLT, OPC_BRANCH};
            MN_BGE:    {w[14:12], w[6:0]} = {F3_BGE, OPC_BRANCH};
            MN_BLTU:   {w[14:12], w[6:0]} = {F3_BLTU, OPC_BRANCH};
            MN_BGEU:   {w[14:12], w[6:0]} = {F3_BGEU, OPC_BRANCH};
            MN_LB:     {w[14:12], w[6:0]} = {F3_BYTE, OPC_LOAD};
            MN_LH:     {w[14:12], w[6:0]} = {F3_HALF, OPC_LOAD};
            MN_LW:     {w[14:12], w[6:0]} = {F3_WORD, OPC_LOAD};
            MN_LBU:    {w[14:12], w[6:0]} = {F3_BYTEU, OPC_LOAD};
            MN_LHU:    {w[14:12], w[6:0]} = {F3_HALFU, OPC_LOAD};
            MN_SB:     {w[14:12], w[6:0]} = {F3_BYTE, OPC_STORE};
            MN_SH:     {w[14:12], w[6:0]} = {F3_HALF, OPC_STORE};
            MN_SW:     {w[14:12], w[6:0]} = {F3_WORD, OPC_STORE};
            MN_ADDI:   {w[14:12], w[6:0]} = {F3_ADD, OPC_OP_IMM};
            MN_SLTI:   {w[14:12], w[6:0]} = {F3_SLT, OPC_OP_IMM};
            MN_SLTIU:  {w[14:12], w[6:0]} = {F3_SLTU, OPC_OP_IMM};
            MN_XORI:   {w[14:12], w[6:0]} = {F3_XOR, OPC_OP_IMM};
            MN_ORI:    {w[14:12], w[6:0]} = {F3_OR, OPC_OP_IMM};
            MN_ANDI:   {w[14:12], w[6:0]} = {F3_AND, OPC_OP_IMM};
            MN_SLLI:   {w[14:12], w[6:0]} = {F3_SLL, OPC_OP_IMM};
            MN_SRLI:   {w[31:25], w[14:12], w[6:0]} = {F7_BASE, F3_SR, OPC_OP_IMM};
            MN_SRAI:   {w[31:25], w[14:12], w[6:0]} = {F7_ALT, F3_SR, OPC_OP_IMM};
            MN_ADD:    {w[31:25], w[14:12], w[6:0]} = {F7_BASE, F3_ADD, OPC_OP};
            MN_SUB:    {w[31:25], w[14:12], w[6:0]} = {F7_ALT, F3_ADD, OPC_OP};
            MN_SLL:    {w[14:12], w[6:0]} = {F3_SLL, OPC_OP};
            MN_SLT:    {w[14:12], w[6:0]} = {F3_SLT, OPC_OP};
            MN_SLTU:   {w[14:12], w[6:0]} = {F3_SLTU, OPC_OP};
            MN_XOR:    {w[14:12], w[6:0]} = {F3_XOR, OPC_OP};
            MN_SRL:    {w[31:25], w[14:12], w[6:0]} = {F7_BASE, F3_SR, OPC_OP};
            MN_SRA:    {w[31:25], w[14:12], w[6:0]} = {F7_ALT, F3_SR, OPC_OP};
            MN_OR:     {w[14:12], w[6:0]} = {F3_OR, OPC_OP};
            MN_AND:    {w[14:12], w[6:0]} = {F3_AND, OPC_OP};
            MN_ECALL:  w = WORD_ECALL;
            MN_EBREAK: w = WORD_EBREAK;
            MN_CSRRW:  {w[14:12], w[6:0]} = {F3_CSRRW, OPC_SYSTEM};
            MN_CSRRS:  {w[14:12], w[6:0]} = {F3_CSRRS, OPC_SYSTEM};
            MN_CSRRC:  {w[14:12], w[6:0]} = {F3_CSRRC, OPC_SYSTEM};
            MN_CSRRWI: {w[14:12], w[6:0]} = {F3_CSRRWI, OPC_SYSTEM};
            MN_CSRRSI: {w[14:12], w[6:0]} = {F3_CSRRSI, OPC_SYSTEM};
            MN_CSRRCI: {w[14:12], w[6:0]} = {F3_CSRRCI, OPC_SYSTEM};
            default:   w = fill;
        endcase
        return w;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic add_row(input logic [31:0] addr, input logic [31:0] word,
                           input bit typed, input result_t decoded);
        stim_row_t row;
        row.addr    = addr;
        row.word    = word;
        row.typed   = typed;
        row.decoded = decoded;
        directed_rows.push_back(row);
    endtask

    // Offer one instruction item after an idle gap; queue its decode on acceptance
    task automatic issue_instr(input logic [31:0] addr, input logic [31:0] word,
                               input result_t decoded, input int unsigned gap);
        pending_t entry;
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_ch.valid      <= 1'b1;
        instr_ch.instr_addr <= addr;
        instr_ch.instr_word <= word;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        entry.word    = word;
        entry.decoded = decoded;
        pending_decodes.push_back(entry);
    endtask

    // Stimulus: reset, directed table, random stream, drain, verdict
    initial
    begin
        int unsigned  roll;
        logic [5:0]   kind;
        logic [31:0]  addr;
        logic [31:0]  word;
        result_t      decoded;
        rst_n               <= 1'b0;
        instr_ch.valid      <= 1'b0;
        instr_ch.instr_addr <= '0;
        instr_ch.instr_word <= '0;

        // Zero word, all-ones word, whole-word system codes and other extremes
        add_row(32'h0000_0000, 32'h0000_0000, 1'b1,
                {MN_LUI, 1'b1, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0});
        add_row(32'hffff_ffff, 32'hffff_ffff, 1'b1,
                {MN_LUI, 1'b1, 5'd31, 5'd31, 5'd31, 32'd0, 32'd0, 12'd0});
        add_row(32'h0000_0100, WORD_ECALL, 1'b1,
                {MN_ECALL, 1'b0, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0});
        add_row(32'h0000_0104, WORD_EBREAK, 1'b1,
                {MN_EBREAK, 1'b0, 5'd0, 5'd0, 5'd1, 32'd0, 32'd0, 12'd0});
        add_row(32'h0000_0108, 32'hffff_f0b7, 1'b1,
                {MN_LUI, 1'b0, 5'd1, 5'd31, 5'd31, 32'h000f_ffff, 32'd0, 12'd0});
        add_row(32'h0000_0000, 32'h8000_006f, 1'b1,
                {MN_JAL, 1'b0, 5'd0, 5'd0, 5'd0, 32'hfff0_0000, 32'hfff0_0000, 12'd0});
        add_row(32'h0000_0200, 32'hfff0_1073, 1'b1,
                {MN_CSRRW, 1'b0, 5'd0, 5'd0, 5'd31, 32'd0, 32'd0, 12'hfff});
        // fence is not decoded
        add_row(32'h0000_0204, 32'h0000_000f, 1'b1,
                {MN_LUI, 1'b1, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 12'd0});
        // jal forward to the far end with address wrap
        add_row(32'hffff_ff00, 32'h7fff_f06f, 1'b0, '0);
        // loosely checked funct fields and near-miss encodings
        add_row(32'h0000_1000, {12'h800, 5'd3, 3'd7, 5'd4, OPC_JALR}, 1'b0, '0);
        add_row(32'h0000_1004, {7'h7f, 5'd31, 5'd1, F3_SLL, 5'd2, OPC_OP_IMM}, 1'b0, '0);
        add_row(32'h0000_1008, {7'h01, 5'd5, 5'd1, F3_SR, 5'd2, OPC_OP_IMM}, 1'b0, '0);
        add_row(32'h0000_100c, {F7_ALT, 5'd31, 5'd7, F3_SR, 5'd8, OPC_OP_IMM}, 1'b0, '0);
        add_row(32'h0000_1010, {7'h40, 5'd3, 5'd2, F3_ADD, 5'd1, OPC_OP}, 1'b0, '0);
        add_row(32'h0000_1014, {F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP}, 1'b0, '0);
        add_row(32'h0000_1018, {7'h7f, 5'd9, 5'd10, F3_SLL, 5'd11, OPC_OP}, 1'b0, '0);
        add_row(32'h0000_101c, 32'h0020_0073, 1'b0, '0);
        add_row(32'h0000_1020, {12'h300, 5'd1, 3'd4, 5'd2, OPC_SYSTEM}, 1'b0, '0);
        add_row(32'h0000_1024, {7'h00, 5'd1, 5'd2, 3'd2, 5'd0, OPC_BRANCH}, 1'b0, '0);
        add_row(32'h0000_1028, {12'hfff, 5'd1, 3'd3, 5'd2, OPC_LOAD}, 1'b0, '0);
        add_row(32'h0000_102c, {7'h7f, 5'd1, 5'd2, 3'd3, 5'd3, OPC_STORE}, 1'b0, '0);
        // branch extremes with wrap in both directions
        add_row(32'h0000_0000, 32'h8000_0063, 1'b0, '0);
        add_row(32'hffff_fffc, {1'b0, 6'h3f, 5'd9, 5'd10, F3_BGEU, 4'hf, 1'b1, OPC_BRANCH},
                1'b0, '0);
        add_row(32'h0000_1030, {7'h7f, 5'd5, 5'd6, F3_WORD, 5'd31, OPC_STORE}, 1'b0, '0);
        add_row(32'h0000_1034, {12'hfff, 5'd0, F3_ADD, 5'd1, OPC_OP_IMM}, 1'b0, '0);
        add_row(32'h0000_1038, {12'h000, 5'd31, F3_CSRRCI, 5'd31, OPC_SYSTEM}, 1'b0, '0);

        // Hold reset, then release
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            decoded = directed_rows[i].typed ? directed_rows[i].decoded
                                             : decode_instr(directed_rows[i].addr,
                                                            directed_rows[i].word);
            issue_instr(directed_rows[i].addr, directed_rows[i].word, decoded, idle_len());
        end

        // Random stream: mostly well-formed kinds, some broken funct fields, some noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps = (n >= 200 && n < 280);
            roll = $urandom_range(0, 99);
            kind = 6'($urandom_range(0, MN_CSRRCI));
            word = encode_kind(kind, $urandom());
            if (roll >= 90)
                word = $urandom();
            else if (roll >= 80)
            begin
                word[14:12] = 3'($urandom());
                word[31:25] = 7'($urandom());
            end
            if ($urandom_range(0, 3) == 0)
                addr = 32'hffff_ff00 | $urandom_range(0, 255);
            else
                addr = $urandom();
            issue_instr(addr, word, decode_instr(addr, word), no_gaps ? 0 : idle_len());
        end
        instr_ch.valid <= 1'b0;

        // Drain outstanding results, then give the pipeline time to show strays
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_decodes.size() != 0)
            failures++;

        $display("decoded %0d instruction items (%0d directed, %0d random), %0d illegal",
                 results_seen, directed_rows.size(), RANDOM_ITEMS, illegal_seen);
        $display("%0d of %0d instruction kinds seen, %0d failures, one long output hold-off",
                 $countones(kinds_seen), NUM_KINDS, failures);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, an idle-free stretch and one long hold-off
    initial
    begin
        int unsigned stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!holdoff_done && results_seen >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = (results_seen >= 320 && results_seen < 400) ? 0 : idle_len();
                if (stall > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest pending decode
    always @(posedge clk)
    begin
        result_t  got;
        pending_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = {result_ch.mnemonic_code, result_ch.illegal, result_ch.dest_reg,
                   result_ch.src1_reg, result_ch.src2_reg, result_ch.immediate,
                   result_ch.target_addr, result_ch.csr_number};
            results_seen++;
            if (pending_decodes.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result item: mn=%0d ill=%0b", got.mnemonic_code,
                             got.illegal);
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (got.mnemonic_code !== want.decoded.mnemonic_code ||
                    got.illegal       !== want.decoded.illegal ||
                    got.dest_reg      !== want.decoded.dest_reg ||
                    got.src1_reg      !== want.decoded.src1_reg ||
                    got.src2_reg      !== want.decoded.src2_reg ||
                    got.immediate     !== want.decoded.immediate ||
                    got.target_addr   !== want.decoded.target_addr ||
                    got.csr_number    !== want.decoded.csr_number)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                    begin
                        $display("mismatch word %h: exp mn=%0d ill=%0b rd=%0d rs1=%0d rs2=%0d",
                                 want.word, want.decoded.mnemonic_code, want.decoded.illegal,
                                 want.decoded.dest_reg, want.decoded.src1_reg,
                                 want.decoded.src2_reg);
                        $display("    exp imm=%h tgt=%h csr=%h", want.decoded.immediate,
                                 want.decoded.target_addr, want.decoded.csr_number);
                        $display("    got mn=%0d ill=%0b rd=%0d rs1=%0d rs2=%0d",
                                 got.mnemonic_code, got.illegal, got.dest_reg,
                                 got.src1_reg, got.src2_reg);
                        $display("    got imm=%h tgt=%h csr=%h", got.immediate,
                                 got.target_addr, got.csr_number);
                    end
                end
                else if (got.illegal)
                    illegal_seen++;
                else
                    kinds_seen[got.mnemonic_code] = 1'b1;
            end
        end
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
